/* rtl/hst_pkg.sv */
// ----------------------------------------------------------------------------
// hst_pkg: shared definitions for the handle slot table
// Sizes, operation and status codes, and the command and status structs that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package hst_pkg;

   localparam int SLOTS    = 64;
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int LIVE_W   = 7;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int HANDLE_W = 32;
   localparam int WORD_W   = 32;
   localparam int POINT_W  = 3 * WORD_W;

   localparam logic [IDX_W-1:0]    LAST_IDX     = IDX_W'(SLOTS - 1);
   localparam logic [HANDLE_W-1:0] HANDLE_LIMIT = 32'hFFFF_FFFF;
   localparam logic [HANDLE_W-1:0] HANDLE_FIRST = 32'd1;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic start;    // latch the accepted request and restart the scan
      logic scan;     // read the next slot and judge the previous one
      logic commit;   // apply the table update and read the point
      logic finish;   // load the response register
   } hst_cmd_type;

   typedef struct packed {
      logic done;     // scan found its slot or passed the last one
      logic out_free; // response register can take a new response
   } hst_stat_type;

endpackage

/* rtl/hst_if.sv */
// ----------------------------------------------------------------------------
// hst_req_if / hst_rsp_if: request and response channels
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface hst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] handle_in;
   logic [31:0] point_x_in;
   logic [31:0] point_y_in;
   logic [31:0] point_z_in;

   modport source (output valid, mode, handle_in, point_x_in, point_y_in, point_z_in,
                   input ready);
   modport sink   (input valid, mode, handle_in, point_x_in, point_y_in, point_z_in,
                   output ready);
endinterface

interface hst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] handle_out;
   logic [31:0] point_x_out;
   logic [31:0] point_y_out;
   logic [31:0] point_z_out;
   logic [6:0]  live_count;

   modport source (output valid, status, handle_out, point_x_out, point_y_out,
                   point_z_out, live_count, input ready);
   modport sink   (input valid, status, handle_out, point_x_out, point_y_out,
                   point_z_out, live_count, output ready);
endinterface

/* rtl/handle_slot_table.sv */
// ----------------------------------------------------------------------------
// handle_slot_table: fixed table of points addressed by issued handles
// Top level joining the request sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// The table holds SLOTS entries, each a three-word point tagged with a 32-bit
// handle. An add request stores its point in the lowest vacant slot and
// returns a fresh handle from a counter that starts at one; remove frees the
// slot that holds a live handle, and get returns that slot's point. Handle
// zero never matches, and once the counter reaches all ones no further adds
// succeed. Each request is handled alone: it is accepted, the slots are scanned
// one per cycle through the handle memory's registered read port, the update
// is committed, and the response register is loaded. A match ends the scan
// at its slot, while a miss or a full table scans every slot, and the block is
// ready again once the response register has been loaded. The response
// register lets the block accept the next request while the previous response
// is still waiting; a new response is only loaded once the old one has been
// taken. Every response reports the live slot count after the operation.
// ----------------------------------------------------------------------------
module handle_slot_table (
   input  logic      clock,
   input  logic      reset,
   hst_req_if.sink   req,
   hst_rsp_if.source rsp
);
   import hst_pkg::*;

   hst_cmd_type  cmd;
   hst_stat_type stat;
   logic         ready;

   // The sequencer owns the request handshake; it is ready only between requests.
   hst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req.ready = ready;

   // The datapath latches the request payload on the start command and drives
   // the response channel from its own register.
   hst_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req.mode),
      .req_handle_in  (req.handle_in),
      .req_point_x_in (req.point_x_in),
      .req_point_y_in (req.point_y_in),
      .req_point_z_in (req.point_z_in),
      .rsp            (rsp)
   );

endmodule

/* rtl/hst_ctrl.sv */
// ----------------------------------------------------------------------------
// hst_ctrl: request sequencer
// Steps each request through accept, slot scan, commit and response load.
// ----------------------------------------------------------------------------
module hst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hst_pkg::hst_stat_type stat,
   output hst_pkg::hst_cmd_type  cmd
);
   import hst_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/hst_dp.sv */
// ----------------------------------------------------------------------------
// hst_dp: slot storage, scan pipeline and response register
// Holds valid marks, handle and point memories, counters, and the result.
// ----------------------------------------------------------------------------
module hst_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  hst_pkg::hst_cmd_type  cmd,
   output hst_pkg::hst_stat_type stat,
   input  logic [1:0]            req_mode,
   input  logic [31:0]           req_handle_in,
   input  logic [31:0]           req_point_x_in,
   input  logic [31:0]           req_point_y_in,
   input  logic [31:0]           req_point_z_in,
   hst_rsp_if.source             rsp
);
   import hst_pkg::*;

   logic [HANDLE_W-1:0] handle_mem [SLOTS];
   logic [POINT_W-1:0]  point_mem  [SLOTS];

   logic [SLOTS-1:0]    valid_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [HANDLE_W-1:0] next_handle_ff;

   logic [MODE_W-1:0]   mode_ff;
   logic [HANDLE_W-1:0] key_ff;
   logic [POINT_W-1:0]  point_ff;

   logic [IDX_W-1:0]    issue_idx_ff;
   logic                issue_on_ff;
   logic                pipe_vld_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_valid_ff;
   logic [HANDLE_W-1:0] rd_handle_ff;

   logic                hit_ff;
   logic [IDX_W-1:0]    hit_idx_ff;

   logic [POINT_W-1:0]  pt_rd_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [HANDLE_W-1:0] res_handle_ff;
   logic                res_get_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [POINT_W-1:0]  rsp_point_ff;
   logic [LIVE_W-1:0]   rsp_live_ff;

   logic match_add;
   logic match_find;
   logic hit;
   logic add_ok;
   logic rem_ok;
   logic get_ok;

   // The slot under judgment is a vacancy for an add, or a live match for a lookup.
   always_comb begin
      match_add  = (mode_ff == MODE_ADD) && !rd_valid_ff;
      match_find = ((mode_ff == MODE_REMOVE) || (mode_ff == MODE_GET)) &&
                   (key_ff != '0) && rd_valid_ff && (rd_handle_ff == key_ff);
      hit        = pipe_vld_ff && (match_add || match_find);
      stat.done     = hit || (pipe_vld_ff && (rd_idx_ff == LAST_IDX));
      stat.out_free = !rsp_valid_ff || rsp.ready;
      add_ok = (mode_ff == MODE_ADD) && hit_ff && (next_handle_ff != HANDLE_LIMIT);
      rem_ok = (mode_ff == MODE_REMOVE) && hit_ff;
      get_ok = (mode_ff == MODE_GET) && hit_ff;
   end

   // Request latch and scan pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
         pipe_vld_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (cmd.start) begin
         issue_on_ff <= 1'b1;
         pipe_vld_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (cmd.scan) begin
         pipe_vld_ff <= issue_on_ff;
         if (issue_on_ff && (issue_idx_ff == LAST_IDX)) begin
            issue_on_ff <= 1'b0;
         end
         if (hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff      <= req_mode;
         key_ff       <= req_handle_in;
         point_ff     <= {req_point_z_in, req_point_y_in, req_point_x_in};
         issue_idx_ff <= '0;
      end else if (cmd.scan) begin
         if (issue_on_ff) begin
            rd_idx_ff    <= issue_idx_ff;
            rd_valid_ff  <= valid_ff[issue_idx_ff];
            issue_idx_ff <= issue_idx_ff + 1'b1;
         end
         if (hit) begin
            hit_idx_ff <= rd_idx_ff;
         end
      end
   end

   // Slot memories: handles are read during the scan, points on commit.
   always_ff @(posedge clock) begin
      if (cmd.scan && issue_on_ff) begin
         rd_handle_ff <= handle_mem[issue_idx_ff];
      end
      if (cmd.commit) begin
         pt_rd_ff <= point_mem[hit_idx_ff];
         if (add_ok) begin
            handle_mem[hit_idx_ff] <= next_handle_ff;
            point_mem[hit_idx_ff]  <= point_ff;
         end
      end
   end

   // Table state and the staged result.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         count_ff       <= '0;
         next_handle_ff <= HANDLE_FIRST;
      end else if (cmd.commit) begin
         if (add_ok) begin
            valid_ff[hit_idx_ff] <= 1'b1;
            count_ff             <= count_ff + 1'b1;
            next_handle_ff       <= next_handle_ff + 1'b1;
         end else if (rem_ok) begin
            valid_ff[hit_idx_ff] <= 1'b0;
            count_ff             <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_get_ff    <= get_ok;
         res_handle_ff <= add_ok ? next_handle_ff : '0;
         if (mode_ff == MODE_ADD) begin
            res_status_ff <= add_ok ? ST_OK : ST_FULL;
         end else begin
            res_status_ff <= (rem_ok || get_ok) ? ST_OK : ST_MISS;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= res_status_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_point_ff  <= res_get_ff ? pt_rd_ff : '0;
         rsp_live_ff   <= LIVE_W'(count_ff);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.handle_out  = rsp_handle_ff;
   assign rsp.point_x_out = rsp_point_ff[WORD_W-1:0];
   assign rsp.point_y_out = rsp_point_ff[2*WORD_W-1:WORD_W];
   assign rsp.point_z_out = rsp_point_ff[3*WORD_W-1:2*WORD_W];
   assign rsp.live_count  = rsp_live_ff;

endmodule
